FILE: src/kpc_pkg.sv
// Shared types, constants and helpers for the keypad press classifier.
// Depends on nothing; the design files refer to it by scoped names, the test files import it.
package kpc_pkg;

  // Key matrix geometry
  localparam int ROW_COUNT = 4;
  localparam int COL_COUNT = 3;
  localparam int KEY_COUNT = ROW_COUNT * COL_COUNT;

  // Field widths of the stream words
  localparam int MASK_W = 12;
  localparam int TIME_W = 32;
  localparam int KIND_W = 2;
  localparam int KEY_W  = 4;
  localparam int CFG_W  = 16;
  localparam int EN_W   = 3;
  localparam int IDX_W  = 2;

  // Only key bits that exist in both the matrix and the mask are scanned
  localparam int SCAN_COUNT = (KEY_COUNT < MASK_W) ? KEY_COUNT : MASK_W;
  // Held-key code: 0 means no key, k+1 means key k
  localparam int CODE_W = $clog2(SCAN_COUNT + 1);

  // Packed word widths, padded to whole bytes
  localparam int IN_BITS  = MASK_W + TIME_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = KIND_W + KEY_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Register reset values
  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = CFG_W'(1000);
  localparam logic [CFG_W-1:0] DEBOUNCE_RST     = CFG_W'(50);
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = CFG_W'(300);
  localparam logic [EN_W-1:0]  EVENT_ENABLE_RST = 3'b111;

  typedef enum logic [KIND_W-1:0] {
    EV_SINGLE = 2'd0,
    EV_DOUBLE = 2'd1,
    EV_LONG   = 2'd2
  } ev_kind_t;

  typedef enum logic [IDX_W-1:0] {
    REG_LONG_PRESS   = 2'd0,
    REG_DEBOUNCE     = 2'd1,
    REG_DOUBLE_CLICK = 2'd2,
    REG_EVENT_ENABLE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] double_click_ms;
    logic [EN_W-1:0]  event_enable;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    ev_kind_t         kind;
    logic [KEY_W-1:0] key;
  } event_t;

  // Tracker status seen by the top level
  typedef struct packed {
    logic key_held;
    logic long_seen;
    logic awaiting;
  } trk_status_t;

endpackage

FILE: src/kpc_encoder.sv
// Priority encoder for the key mask: lowest pressed key wins.
// Depends on kpc_pkg for the scan count and code width.
module kpc_encoder (
  input  logic [kpc_pkg::MASK_W-1:0] mask,
  output logic [kpc_pkg::CODE_W-1:0] code
);

  // Walk from the top down so the lowest set bit is written last
  always_comb begin
    code = '0;
    for (int i = kpc_pkg::SCAN_COUNT - 1; i >= 0; i--) begin
      if (mask[i]) begin
        code = kpc_pkg::CODE_W'(i + 1);
      end
    end
  end

endmodule

FILE: src/kpc_tracker.sv
// Press tracking state and event classification for one scan tick.
// Depends on kpc_pkg for types and widths.
module kpc_tracker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [kpc_pkg::CODE_W-1:0]   code,
  input  logic [kpc_pkg::TIME_W-1:0]   now_ms,
  input  kpc_pkg::cfg_t                cfg,
  output kpc_pkg::event_t              ev,
  output kpc_pkg::trk_status_t         status
);

  logic [kpc_pkg::CODE_W-1:0] held_key, held_key_next;
  logic [kpc_pkg::TIME_W-1:0] press_time, press_time_next;
  logic [kpc_pkg::TIME_W-1:0] release_time, release_time_next;
  logic                       long_seen, long_seen_next;
  logic                       awaiting_second, awaiting_second_next;
  logic [kpc_pkg::KEY_W-1:0]  released_key, released_key_next;

  logic [kpc_pkg::TIME_W-1:0] since_press;
  logic [kpc_pkg::TIME_W-1:0] since_release;
  logic [kpc_pkg::TIME_W-1:0] long_lim, deb_lim, dbl_lim;
  logic [kpc_pkg::KEY_W-1:0]  code_key, held_idx;
  logic                       raw_valid;
  kpc_pkg::ev_kind_t          raw_kind;
  logic [kpc_pkg::KEY_W-1:0]  raw_key;
  logic                       kind_en;

  // Wrapping time differences against zero-extended limits
  assign since_press   = now_ms - press_time;
  assign since_release = now_ms - release_time;
  assign long_lim      = kpc_pkg::TIME_W'(cfg.long_press_ms);
  assign deb_lim       = kpc_pkg::TIME_W'(cfg.debounce_ms);
  assign dbl_lim       = kpc_pkg::TIME_W'(cfg.double_click_ms);
  assign code_key      = kpc_pkg::KEY_W'(code - kpc_pkg::CODE_W'(1));
  assign held_idx      = kpc_pkg::KEY_W'(held_key - kpc_pkg::CODE_W'(1));

  // Next state and raw event
  always_comb begin
    held_key_next        = held_key;
    press_time_next      = press_time;
    release_time_next    = release_time;
    long_seen_next       = long_seen;
    awaiting_second_next = awaiting_second;
    released_key_next    = released_key;
    raw_valid            = 1'b0;
    raw_kind             = kpc_pkg::EV_SINGLE;
    raw_key              = released_key;
    if (code != '0) begin
      if (held_key != code) begin
        // new press, also when the key changes while held
        held_key_next   = code;
        press_time_next = now_ms;
        long_seen_next  = 1'b0;
      end else if (!long_seen && (since_press > long_lim)) begin
        long_seen_next       = 1'b1;
        awaiting_second_next = 1'b0;
        raw_valid            = 1'b1;
        raw_kind             = kpc_pkg::EV_LONG;
        raw_key              = code_key;
      end
    end else if (held_key != '0) begin
      // release; double test uses the previous release time
      release_time_next = now_ms;
      released_key_next = held_idx;
      held_key_next     = '0;
      raw_key           = held_idx;
      if (!long_seen && !awaiting_second) begin
        awaiting_second_next = 1'b1;
      end else if (awaiting_second) begin
        awaiting_second_next = 1'b0;
        if ((since_release > deb_lim) && (since_press < dbl_lim)) begin
          raw_valid = 1'b1;
          raw_kind  = kpc_pkg::EV_DOUBLE;
        end else if (!long_seen) begin
          raw_valid = 1'b1;
          raw_kind  = kpc_pkg::EV_SINGLE;
        end
      end
    end else if (awaiting_second && (since_release > dbl_lim)) begin
      // single-press timeout
      awaiting_second_next = 1'b0;
      if (!long_seen) begin
        raw_valid = 1'b1;
        raw_kind  = kpc_pkg::EV_SINGLE;
      end
    end
  end

  // Per-kind reporting enable
  always_comb begin
    unique case (raw_kind)
      kpc_pkg::EV_SINGLE: kind_en = cfg.event_enable[0];
      kpc_pkg::EV_DOUBLE: kind_en = cfg.event_enable[1];
      kpc_pkg::EV_LONG:   kind_en = cfg.event_enable[2];
      default:            kind_en = 1'b0;
    endcase
  end

  assign ev.valid = raw_valid && kind_en;
  assign ev.kind  = raw_kind;
  assign ev.key   = raw_key;

  assign status.key_held  = (held_key != '0);
  assign status.long_seen = long_seen;
  assign status.awaiting  = awaiting_second;

  // State registers, updated once per processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      held_key        <= '0;
      press_time      <= '0;
      release_time    <= '0;
      long_seen       <= 1'b0;
      awaiting_second <= 1'b0;
      released_key    <= '0;
    end else if (step) begin
      held_key        <= held_key_next;
      press_time      <= press_time_next;
      release_time    <= release_time_next;
      long_seen       <= long_seen_next;
      awaiting_second <= awaiting_second_next;
      released_key    <= released_key_next;
    end
  end

endmodule

FILE: src/keypad_press_classifier.sv
// Keypad press classifier: single, double and long press events per scan tick.
// An accepted scan word passes the input register, then the result register, before its event word goes out.
// Throughput: one scan word per cycle, except while an event waits on a full, stalled result register.
// A stalled result register holds one event while one more scan word waits in the input register.
// Reset (rst, synchronous) clears the tracker state, empties both registers and loads register defaults.
module keypad_press_classifier (
  input  logic                          clk,
  input  logic                          rst,
  // scan words: [11:0] pressed_mask, [43:12] now_ms, upper bits zero
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [kpc_pkg::IN_W-1:0]      s_tdata,
  // event words: [1:0] event_kind, [5:2] key_index, upper bits zero
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [kpc_pkg::OUT_W-1:0]     m_tdata,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kpc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [kpc_pkg::CFG_W-1:0]     cfg_data
);

  kpc_pkg::cfg_t                 cfg;
  logic                          in_valid;
  logic [kpc_pkg::MASK_W-1:0]    in_mask;
  logic [kpc_pkg::TIME_W-1:0]    in_now;
  logic [kpc_pkg::CODE_W-1:0]    code;
  kpc_pkg::event_t               ev;
  kpc_pkg::trk_status_t          status;
  logic                          out_free;
  logic                          fire;
  logic                          out_valid;
  kpc_pkg::ev_kind_t             out_kind;
  logic [kpc_pkg::KEY_W-1:0]     out_key;

  // Configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ms   <= kpc_pkg::LONG_PRESS_RST;
      cfg.debounce_ms     <= kpc_pkg::DEBOUNCE_RST;
      cfg.double_click_ms <= kpc_pkg::DOUBLE_CLICK_RST;
      cfg.event_enable    <= kpc_pkg::EVENT_ENABLE_RST;
    end else if (cfg_valid) begin
      unique case (kpc_pkg::cfg_reg_t'(cfg_index))
        kpc_pkg::REG_LONG_PRESS:   cfg.long_press_ms   <= cfg_data;
        kpc_pkg::REG_DEBOUNCE:     cfg.debounce_ms     <= cfg_data;
        kpc_pkg::REG_DOUBLE_CLICK: cfg.double_click_ms <= cfg_data;
        kpc_pkg::REG_EVENT_ENABLE: cfg.event_enable    <= cfg_data[kpc_pkg::EN_W-1:0];
        default: ;
      endcase
    end
  end

  // A tick is processed unless it makes an event that cannot be stored
  assign out_free = !out_valid || m_tready;
  assign fire     = in_valid && (!ev.valid || out_free);
  assign s_tready = !in_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mask <= s_tdata[kpc_pkg::MASK_W-1:0];
      in_now  <= s_tdata[kpc_pkg::MASK_W +: kpc_pkg::TIME_W];
    end
  end

  kpc_encoder u_encoder (
    .mask (in_mask),
    .code (code)
  );

  kpc_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .step   (fire),
    .code   (code),
    .now_ms (in_now),
    .cfg    (cfg),
    .ev     (ev),
    .status (status)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && ev.valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ev.valid) begin
      out_kind <= ev.kind;
      out_key  <= ev.key;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = kpc_pkg::OUT_W'({out_key, out_kind});

  // A waiting input word is held until processed
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid && $stable(in_now) && $stable(in_mask))
    else $error("input register lost a pending scan word");

  // A long event leaves the key held with its long flag set
  a_long_state: assert property (@(posedge clk) disable iff (rst)
    fire && ev.valid && (ev.kind == kpc_pkg::EV_LONG) |=> status.long_seen && status.key_held)
    else $error("long event without matching tracker state");

  // Single and double events end the wait for a second click
  a_click_clears: assert property (@(posedge clk) disable iff (rst)
    fire && ev.valid && (ev.kind != kpc_pkg::EV_LONG) |=> !status.awaiting && !status.key_held)
    else $error("click event left tracker waiting or held");

  // Waiting for a second click never coexists with a reported long press
  a_wait_long: assert property (@(posedge clk) disable iff (rst)
    !(status.awaiting && status.long_seen))
    else $error("tracker waiting after a long press");

endmodule

FILE: tb/sv/kpc_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the keypad press classifier test: press tracking and event queue.
// Depends on kpc_pkg for widths, the event kinds and the register indexes.
package kpc_tb_pkg;
  import kpc_pkg::*;

  typedef struct {
    ev_kind_t         kind;
    logic [KEY_W-1:0] key;
  } press_event_t;

  class press_scoreboard;
    // register copies
    logic [CFG_W-1:0] long_ms;
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] double_ms;
    logic [EN_W-1:0]  enables;
    // tracker state; held_code is 0 for no key, k+1 for key k
    logic [KEY_W-1:0]  held_code;
    logic [TIME_W-1:0] press_t;
    logic [TIME_W-1:0] release_t;
    bit                long_seen;
    bit                awaiting;
    logic [KEY_W-1:0]  released_key;
    press_event_t      expected_events[$];
    int                errors;

    function new();
      long_ms      = LONG_PRESS_RST;
      debounce_ms  = DEBOUNCE_RST;
      double_ms    = DOUBLE_CLICK_RST;
      enables      = EVENT_ENABLE_RST;
      held_code    = '0;
      press_t      = '0;
      release_t    = '0;
      long_seen    = 1'b0;
      awaiting     = 1'b0;
      released_key = '0;
      errors       = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_LONG_PRESS:   long_ms = value;
        REG_DEBOUNCE:     debounce_ms = value;
        REG_DOUBLE_CLICK: double_ms = value;
        REG_EVENT_ENABLE: enables = value[EN_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    // disabled kinds are dropped, the tracker state moves on regardless
    function void post(ev_kind_t kind, logic [KEY_W-1:0] key);
      press_event_t ev;
      if (enables[kind]) begin
        ev.kind = kind;
        ev.key  = key;
        expected_events.push_back(ev);
      end
    endfunction

    // one accepted scan word
    function void note_scan(logic [MASK_W-1:0] mask, logic [TIME_W-1:0] now);
      logic [KEY_W-1:0]  code;
      logic [TIME_W-1:0] prev_release;
      // lowest pressed key wins
      code = '0;
      for (int i = KEY_COUNT - 1; i >= 0; i--)
        if (mask[i]) code = KEY_W'(i + 1);

      if (code != '0) begin
        // a different key is a fresh press, no release in between
        if (held_code != code) begin
          held_code = code;
          press_t   = now;
          long_seen = 1'b0;
        end else if (!long_seen && (now - press_t) > TIME_W'(long_ms)) begin
          long_seen = 1'b1;
          awaiting  = 1'b0;
          post(EV_LONG, code - KEY_W'(1));
        end
      end else if (held_code != '0) begin
        // release
        prev_release = release_t;
        release_t    = now;
        released_key = held_code - KEY_W'(1);
        held_code    = '0;
        if (!long_seen && !awaiting) begin
          awaiting = 1'b1;
        end else if (awaiting) begin
          awaiting = 1'b0;
          if ((now - prev_release) > TIME_W'(debounce_ms) &&
              (now - press_t) < TIME_W'(double_ms))
            post(EV_DOUBLE, released_key);
          else if (!long_seen)
            post(EV_SINGLE, released_key);
        end
      end else if (awaiting && (now - release_t) > TIME_W'(double_ms)) begin
        // no second click inside the window
        awaiting = 1'b0;
        if (!long_seen) post(EV_SINGLE, released_key);
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // one accepted event word against the oldest expected event
    task check_event(logic [OUT_W-1:0] word);
      press_event_t ev;
      if (expected_events.size() == 0) begin
        report($sformatf("event word %h arrived with none expected", word));
        return;
      end
      ev = expected_events.pop_front();
      if (word[KIND_W-1:0] !== ev.kind)
        report($sformatf("event kind %0d, expected %0d", word[KIND_W-1:0], ev.kind));
      if (word[KIND_W +: KEY_W] !== ev.key)
        report($sformatf("key index %0d, expected %0d", word[KIND_W +: KEY_W], ev.key));
    endtask
  endclass

endpackage

FILE: tb/sv/keypad_press_classifier_test.sv
`timescale 1ns / 1ps
// Self-checking test of keypad_press_classifier: directed and random key scans.
// Depends on kpc_pkg and kpc_tb_pkg (scoreboard); drives the block through its stream ports.
module keypad_press_classifier_test;
  import kpc_pkg::*;
  import kpc_tb_pkg::*;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  press_scoreboard   sb;
  logic [TIME_W-1:0] scan_t;
  int                cur_key;
  int                last_key;
  bit                idle_on;
  bit                long_hold_req;

  keypad_press_classifier u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // handshake monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (s_tvalid && s_tready) sb.note_scan(s_tdata[MASK_W-1:0], s_tdata[MASK_W +: TIME_W]);
      if (m_tvalid && m_tready) sb.check_event(m_tdata);
    end
  end

  // event receiver: random stall bursts, one long hold-off on request
  initial begin
    int hold;
    hold     = 0;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(0, 9);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // one scan word, with an optional idle burst ahead of it
  task automatic send_scan(input logic [MASK_W-1:0] mask, input logic [TIME_W-1:0] now);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({now, mask});
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic tick(input logic [MASK_W-1:0] mask, input logic [TIME_W-1:0] gap);
    scan_t = scan_t + gap;
    send_scan(mask, scan_t);
  endtask

  // valid stays high across the writes, lowered by apply_settings
  task automatic program_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] long_ms, input logic [CFG_W-1:0] deb_ms,
                                input logic [CFG_W-1:0] dbl_ms, input logic [EN_W-1:0] en);
    program_reg(REG_LONG_PRESS, long_ms);
    program_reg(REG_DEBOUNCE, deb_ms);
    program_reg(REG_DOUBLE_CLICK, dbl_ms);
    program_reg(REG_EVENT_ENABLE, CFG_W'(en));
    cfg_valid <= 1'b0;
  endtask

  // stop offering, wait for every expected event, then let the pipeline settle
  task automatic end_phase();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(negedge clk);
  endtask

  // time step scaled to one of the current thresholds, sometimes right at it
  function automatic logic [TIME_W-1:0] pick_gap();
    int unsigned base;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom;
    case ($urandom_range(0, 2))
      0:       base = 32'(sb.long_ms);
      1:       base = 32'(sb.debounce_ms);
      default: base = 32'(sb.double_ms);
    endcase
    if (r < 20) return (base == 0) ? $urandom_range(0, 2) : base - 1 + $urandom_range(0, 2);
    return $urandom_range(0, base / 3 + 2);
  endfunction

  // random scan: mostly press / hold / release sessions, some noise masks
  task automatic random_scan();
    int               r;
    logic [MASK_W-1:0] mask;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      mask = MASK_W'($urandom);
      cur_key = -1;
      for (int i = KEY_COUNT - 1; i >= 0; i--)
        if (mask[i]) cur_key = i;
    end else if (cur_key >= 0) begin
      if (r < 55) begin
        // keep holding, at times with other keys of lower priority down too
        mask = MASK_W'(1) << cur_key;
        if ($urandom_range(0, 3) == 0)
          mask |= MASK_W'($urandom) & ~((MASK_W'(2) << cur_key) - MASK_W'(1));
      end else if (r < 92) begin
        mask = '0;
        last_key = cur_key;
        cur_key = -1;
      end else begin
        cur_key = $urandom_range(0, KEY_COUNT - 1);
        mask = MASK_W'(1) << cur_key;
      end
    end else if (r < 50) begin
      // second clicks reuse the key just released about half the time
      if ($urandom_range(0, 1) == 1 && last_key >= 0) cur_key = last_key;
      else cur_key = $urandom_range(0, KEY_COUNT - 1);
      mask = MASK_W'(1) << cur_key;
    end else begin
      mask = '0;
    end
    scan_t = scan_t + pick_gap();
    send_scan(mask, scan_t);
  endtask

  // directed scans under the reset settings
  task automatic directed_scans();
    scan_t = '0;
    send_scan(12'h000, scan_t);
    // single press of key 0, reported after the click window
    tick(12'h001, 10);
    tick(12'h000, 90);
    tick(12'h000, 400);
    // double press of key 11
    tick(12'h800, 100);
    tick(12'h000, 50);
    tick(12'h800, 100);
    tick(12'h000, 100);
    // all keys down: key 0 counts, long press, silent release
    tick(12'hFFF, 500);
    tick(12'hFFF, 1001);
    tick(12'hFFF, 10);
    tick(12'h000, 10);
    // key changes while held, then single press of the new key
    tick(12'h010, 500);
    tick(12'h020, 5);
    tick(12'h000, 50);
    tick(12'h000, 301);
    // second click held too long: single
    tick(12'h004, 1000);
    tick(12'h000, 100);
    tick(12'h004, 100);
    tick(12'h000, 400);
    // second click inside the debounce gap: single
    tick(12'h008, 500);
    tick(12'h000, 10);
    tick(12'h008, 10);
    tick(12'h000, 10);
    // long press across the time wrap
    scan_t = 32'hFFFF_FFFF;
    send_scan(12'h400, scan_t);
    tick(12'h400, 1001);
    tick(12'h000, 1);
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_LONG_PRESS;
    cfg_data      = '0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    cur_key       = -1;
    last_key      = -1;
    scan_t        = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_scans();
    repeat (150) random_scan();

    for (int p = 1; p < 8; p++) begin
      end_phase();
      case (p)
        1: apply_settings(16'd0, 16'd0, 16'd0, 3'b111);
        2: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111);
        3: apply_settings(16'd200, 16'd20, 16'd150, 3'b101);
        4: apply_settings(16'd1000, 16'd50, 16'd300, 3'b010);
        5: begin
          apply_settings(CFG_W'($urandom_range(0, 2000)), CFG_W'($urandom_range(0, 200)),
                         CFG_W'($urandom_range(0, 1500)), 3'b111);
          long_hold_req = 1'b1;
        end
        6: apply_settings(16'd500, 16'd10, 16'd400, 3'b000);
        default: begin
          apply_settings(16'd400, 16'd30, 16'd250, 3'b111);
          idle_on = 1'b0;
        end
      endcase
      repeat (175) random_scan();
    end
    end_phase();

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
src/kpc_pkg.sv
src/kpc_encoder.sv
src/kpc_tracker.sv
src/keypad_press_classifier.sv
tb/sv/kpc_tb_pkg.sv
tb/sv/keypad_press_classifier_test.sv
